@@ hw/rtl/tpms_pkg.sv @@
`timescale 1ns / 1ps

package tpms_pkg;

  localparam int unsigned StackDepth = 8192;
  localparam int unsigned LetterW    = 5;
  localparam int unsigned NumW       = 13;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  typedef enum logic {
    KIND_HUNTER = 1'b0,
    KIND_GHOST  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               kind;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic            pair_found;
    logic [NumW-1:0] hunter_number;
    logic [NumW-1:0] ghost_number;
    logic            done_res;
    logic            all_matched;
  } out_item_t;

  // classified symbol handed from front to back
  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               kind;
    logic               last;
    logic [NumW-1:0]    num;
  } work_t;

  // one stack entry
  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               kind;
    logic [NumW-1:0]    num;
  } entry_t;

endpackage

@@ hw/rtl/tpms_front.sv @@
`timescale 1ns / 1ps

module tpms_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  tpms_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output tpms_pkg::work_t     q_item_o
);

  logic [tpms_pkg::NumW-1:0] hunt_q, hunt_d;
  logic [tpms_pkg::NumW-1:0] ghost_q, ghost_d;
  logic [tpms_pkg::NumW-1:0] num;
  logic                      accept;

  assign accept = in_valid_i && !q_full_i;
  assign num    = (in_item_i.kind == tpms_pkg::KIND_GHOST) ? ghost_q : hunt_q;

  always_comb begin
    hunt_d  = hunt_q;
    ghost_d = ghost_q;
    if (accept) begin
      if (in_item_i.last) begin
        hunt_d  = tpms_pkg::NumW'(1);
        ghost_d = tpms_pkg::NumW'(1);
      end else if (in_item_i.kind == tpms_pkg::KIND_GHOST) begin
        // saturate at all ones
        if (ghost_q != '1) ghost_d = ghost_q + tpms_pkg::NumW'(1);
      end else begin
        if (hunt_q != '1) hunt_d = hunt_q + tpms_pkg::NumW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q  <= tpms_pkg::NumW'(1);
      ghost_q <= tpms_pkg::NumW'(1);
    end else begin
      hunt_q  <= hunt_d;
      ghost_q <= ghost_d;
    end
  end

  assign q_push_o        = accept;
  assign q_item_o.letter = in_item_i.letter;
  assign q_item_o.kind   = in_item_i.kind;
  assign q_item_o.last   = in_item_i.last;
  assign q_item_o.num    = num;

endmodule

@@ hw/rtl/tpms_fifo.sv @@
`timescale 1ns / 1ps

module tpms_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpms_pkg::work_t   push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output tpms_pkg::work_t   item_o
);

  tpms_pkg::work_t                 slots_q [tpms_pkg::FifoDepth];
  logic [tpms_pkg::FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [tpms_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = cnt_q == tpms_pkg::FifoCntW'(tpms_pkg::FifoDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = slots_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + tpms_pkg::FifoCntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - tpms_pkg::FifoCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= wptr_q + tpms_pkg::FifoPtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + tpms_pkg::FifoPtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= push_item_i;
  end

endmodule

@@ hw/rtl/tpms_back.sv @@
`timescale 1ns / 1ps

module tpms_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tpms_pkg::work_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tpms_pkg::out_item_t out_item_o
);

  // top of stack lives in top_q; the memory holds the entries below it
  tpms_pkg::entry_t            stack_mem [tpms_pkg::StackDepth];
  tpms_pkg::entry_t            top_q, top_d;
  tpms_pkg::entry_t            rdata_q, byp_data_q, below;
  logic                        byp_q;
  logic [tpms_pkg::CntW-1:0]   count_q, count_d, count_op, raddr_full;
  logic [tpms_pkg::AddrW-1:0]  raddr, waddr;
  logic                        ovf_q, ovf_d, ovf_op;
  logic                        advance, take, have_top, match, full, wr_en;
  logic                        res_valid;
  tpms_pkg::out_item_t         res, out_q;
  logic                        out_valid_q;
  logic [tpms_pkg::CntW-1:0]   waddr_full;

  assign advance  = !out_valid_q || !out_stall_i;
  assign take     = q_valid_i && advance;
  assign q_pop_o  = take;
  assign have_top = count_q != '0;
  assign full     = count_q == tpms_pkg::CntW'(tpms_pkg::StackDepth);
  assign match    = have_top && (top_q.letter == q_item_i.letter) &&
                    (top_q.kind != q_item_i.kind);
  assign below    = byp_q ? byp_data_q : rdata_q;

  always_comb begin
    count_op = count_q;
    ovf_op   = ovf_q;
    top_d    = top_q;
    wr_en    = 1'b0;
    if (take) begin
      if (match) begin
        count_op = count_q - tpms_pkg::CntW'(1);
        top_d    = below;
      end else if (!full) begin
        // spill the old top below the new one
        wr_en       = have_top;
        count_op    = count_q + tpms_pkg::CntW'(1);
        top_d.letter = q_item_i.letter;
        top_d.kind   = q_item_i.kind;
        top_d.num    = q_item_i.num;
      end else begin
        ovf_op = 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_op;
    ovf_d   = ovf_op;
    if (take && q_item_i.last) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_comb begin
    res = '0;
    res_valid = take && (match || q_item_i.last);
    if (match) begin
      res.pair_found = 1'b1;
      if (q_item_i.kind == tpms_pkg::KIND_GHOST) begin
        res.ghost_number  = q_item_i.num;
        res.hunter_number = top_q.num;
      end else begin
        res.hunter_number = q_item_i.num;
        res.ghost_number  = top_q.num;
      end
    end
    res.done_res    = q_item_i.last;
    res.all_matched = q_item_i.last && (count_op == '0) && !ovf_op;
  end

  assign waddr_full = count_q - tpms_pkg::CntW'(1);
  assign waddr      = waddr_full[tpms_pkg::AddrW-1:0];
  // prefetch the entry that sits below the next top
  assign raddr_full = count_d - tpms_pkg::CntW'(2);
  assign raddr      = raddr_full[tpms_pkg::AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[waddr] <= top_q;
    rdata_q <= stack_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    byp_data_q <= top_q;
    if (advance && res_valid) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      // a spill writes the address being prefetched; forward it instead
      byp_q   <= wr_en;
      if (advance) out_valid_q <= res_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/typed_pair_matching_stack.sv @@
`timescale 1ns / 1ps

// Pairs letter symbols of two kinds (hunter, ghost) on a stack.
// Input channel: in_valid_i / in_stall_o / in_item_i {letter, kind, last}.
// An item is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i / out_item_o. A result is given
// when a symbol closes a pair with the stack top, on the last symbol, or both.
// The last symbol's result carries the verdict, then stack, counters and the
// overflow flag are cleared for the next string.
// A taken item is written into the queue, and its result into the output
// register that drives out_valid_o and out_item_o.
// Throughput: one item per cycle while the output is not stalled; the stack
// top is held in a register and the entry below it is prefetched from the
// single-port-read stack memory every cycle, so a pop never waits on memory.
// A two-entry queue separates the numbering front end from the stack back
// end. When out_stall_i is high the output register holds its result, the
// queue fills and in_stall_o rises once it is full.
// Reset clears the stack count, counters (to one) and the overflow flag; the
// stack memory needs no clearing and the block takes items right away.
module typed_pair_matching_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpms_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tpms_pkg::out_item_t out_item_o
);

  logic            push, full, fifo_valid, pop;
  tpms_pkg::work_t push_item, fifo_item;

  tpms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_item_o   (push_item)
  );

  tpms_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .item_o      (fifo_item)
  );

  tpms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (fifo_valid),
    .q_item_i    (fifo_item),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = full;

  a_result_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pair_found || out_item_o.done_res))
    else $error("result with neither pair nor done");

  a_pair_numbers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.pair_found) |->
      (out_item_o.hunter_number != '0 && out_item_o.ghost_number != '0))
    else $error("pair with a zero sequence number");

  a_verdict_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.all_matched) |-> out_item_o.done_res)
    else $error("verdict outside the last result");

  a_accept_queues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> fifo_valid)
    else $error("accepted item missing from queue");

endmodule
